/* rtl/core/rhbt_pkg.sv */
// Shared types and constants of the resource hazard barrier tracker.
// Depends on nothing; the tracker and its accumulator import it.
`default_nettype none

package rhbt_pkg;

  localparam int NUM_RESOURCES = 64;
  localparam int MAX_MIPS      = 16;
  localparam int TABLE_DEPTH   = NUM_RESOURCES * MAX_MIPS;
  localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int RES_W    = 6;
  localparam int MIP_W    = 4;
  localparam int CNT_W    = 5;
  localparam int MASK_W   = 48;
  localparam int LAYOUT_W = 8;

  localparam logic [LAYOUT_W-1:0] LAYOUT_UNDEFINED = '0;

  // One table entry: the masks gathered since the last barrier and the layout.
  typedef struct packed {
    logic [MASK_W-1:0]   stages;
    logic [MASK_W-1:0]   rd;
    logic [MASK_W-1:0]   wr;
    logic [LAYOUT_W-1:0] layout;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Summary of the entries gathered over a mip range.
  typedef struct packed {
    logic [MASK_W-1:0]   stages;
    logic [MASK_W-1:0]   rd;
    logic [MASK_W-1:0]   wr;
    logic [LAYOUT_W-1:0] first_layout;
    logic                mixed;
  } acc_t;

endpackage

`default_nettype wire

/* rtl/core/rhbt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module rhbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rhbt_accum.sv */
// OR and layout-compare unit that folds table entries one per cycle while enabled.
// Depends on rhbt_pkg.
`default_nettype none

module rhbt_accum
  import rhbt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire logic   en,
  input  wire entry_t din,
  output acc_t        acc
);

  logic   first_r;
  acc_t   acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (start) begin
      first_r <= 1'b1;
    end else if (en) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r.stages <= acc_r.stages | din.stages;
      acc_r.rd     <= acc_r.rd | din.rd;
      acc_r.wr     <= acc_r.wr | din.wr;
      if (first_r) begin
        acc_r.first_layout <= din.layout;
      end else if (din.layout != acc_r.first_layout) begin
        acc_r.mixed <= 1'b1;
      end
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* rtl/core/resource_hazard_barrier_tracker.sv */
// Top level of the resource hazard barrier tracker: sequencer, table RAM, output register.
// Depends on rhbt_pkg, rhbt_ram and rhbt_accum.
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  resource, is_image, mip range, masks, layout, discard
// out_      output     out_valid/out_stall barrier fields, range_error, last
//
// After reset a clearing pass writes zero into all 1024 table entries, one per
// cycle, and no request is taken until that pass is done.
// A request over n mips first reads and merges the range through the single
// read port of the table RAM (registered read). With no hazard it then folds
// the new masks into every mip; with a hazard it overwrites the range and
// emits one output transaction, or, when the layouts differ, reads, writes
// and emits a barrier for each mip in turn, so each mip gets its own barrier.
// A buffer is a range of one mip. A bad range or resource goes straight to
// the output transaction. A stalled output holds the sequencer where it is.

module resource_hazard_barrier_tracker
  import rhbt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [RES_W-1:0]    in_resource,
  input  wire logic                in_is_image,
  input  wire logic [MIP_W-1:0]    in_base_mip,
  input  wire logic [CNT_W-1:0]    in_mip_count,
  input  wire logic [MASK_W-1:0]   in_new_stages,
  input  wire logic [MASK_W-1:0]   in_new_read,
  input  wire logic [MASK_W-1:0]   in_new_write,
  input  wire logic [LAYOUT_W-1:0] in_new_layout,
  input  wire logic                in_discard,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [RES_W-1:0]         out_barrier_resource,
  output logic [MIP_W-1:0]         out_barrier_base_mip,
  output logic [CNT_W-1:0]         out_barrier_mip_count,
  output logic [MASK_W-1:0]        out_wait_stages,
  output logic [MASK_W-1:0]        out_wait_access,
  output logic [MASK_W-1:0]        out_next_stages,
  output logic [MASK_W-1:0]        out_next_access,
  output logic [LAYOUT_W-1:0]      out_prior_layout,
  output logic [LAYOUT_W-1:0]      out_target_layout,
  output logic                     out_range_error,
  output logic                     out_last
);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_GATHER = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_ORW    = 4'd4;
  localparam logic [3:0] ST_OVW    = 4'd5;
  localparam logic [3:0] ST_EMIT   = 4'd6;
  localparam logic [3:0] ST_MIXRD  = 4'd7;
  localparam logic [3:0] ST_MIXWT  = 4'd8;
  localparam logic [3:0] ST_MIXOUT = 4'd9;

  localparam int CHK_W = 14;

  logic [3:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic [CNT_W-1:0]    rcv_r, rcv_nxt;
  logic                rvld_r, rvld_nxt;

  // Request registers, loaded when a transaction is accepted.
  logic [RES_W-1:0]    res_r;
  logic                img_r;
  logic [MIP_W-1:0]    base_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MASK_W-1:0]   ns_r, nr_r, nw_r;
  logic [LAYOUT_W-1:0] nl_r;
  logic                disc_r;
  logic [ADDR_W-1:0]   baddr_r;

  // Output register.
  logic [RES_W-1:0]    o_res_r, o_res_nxt;
  logic [MIP_W-1:0]    o_base_r, o_base_nxt;
  logic [CNT_W-1:0]    o_cnt_r, o_cnt_nxt;
  logic [MASK_W-1:0]   o_ss_r, o_ss_nxt;
  logic [MASK_W-1:0]   o_sa_r, o_sa_nxt;
  logic [MASK_W-1:0]   o_ds_r, o_ds_nxt;
  logic [MASK_W-1:0]   o_da_r, o_da_nxt;
  logic [LAYOUT_W-1:0] o_ol_r, o_ol_nxt;
  logic [LAYOUT_W-1:0] o_tl_r, o_tl_nxt;
  logic                o_err_r, o_err_nxt;
  logic                o_last_r, o_last_nxt;

  logic                in_accept, out_accept;
  logic                req_err;
  logic [CHK_W-1:0]    range_end;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]  ram_rdata_raw;

  acc_t                acc;
  logic                acc_start;
  logic                mixed_eff;
  logic [LAYOUT_W-1:0] ol_eff;
  logic                hazard;
  logic [ADDR_W-1:0]   iss_addr, rcv_addr;
  logic                iss_more, rcv_last, iss_last;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state_r == ST_EMIT) || (state_r == ST_MIXOUT);
  assign out_accept = out_valid && !out_stall;

  // A request is rejected for a resource past the table or, for an image, an
  // empty range or one that runs past the last mip level.
  assign range_end = CHK_W'(in_base_mip) + CHK_W'(in_mip_count);
  assign req_err   = (CHK_W'(in_resource) >= CHK_W'(NUM_RESOURCES)) ||
                     (in_is_image && ((in_mip_count == '0) ||
                                      (range_end > CHK_W'(MAX_MIPS))));

  assign iss_addr = baddr_r + ADDR_W'(iss_r);
  assign rcv_addr = baddr_r + ADDR_W'(rcv_r);
  assign iss_more = (iss_r != cnt_r);
  assign iss_last = (iss_r == cnt_r - CNT_W'(1));
  assign rcv_last = (rcv_r == cnt_r - CNT_W'(1));

  // Hazard decision over the gathered range. A discard drops the old layout
  // and any layout mix. Buffers never look at layouts.
  assign mixed_eff = acc.mixed && !disc_r;
  assign ol_eff    = disc_r ? LAYOUT_UNDEFINED : acc.first_layout;
  assign hazard    = mixed_eff || (acc.wr != '0) || ((acc.rd != '0) && (nw_r != '0)) ||
                     (img_r && (ol_eff != nl_r));

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign acc_start = in_accept;

  rhbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  rhbt_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc_start),
    .en    (rvld_r && (state_r == ST_GATHER)),
    .din   (ram_rdata),
    .acc   (acc)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    iss_nxt      = iss_r;
    rcv_nxt      = rcv_r;
    rvld_nxt     = 1'b0;

    o_res_nxt  = o_res_r;
    o_base_nxt = o_base_r;
    o_cnt_nxt  = o_cnt_r;
    o_ss_nxt   = o_ss_r;
    o_sa_nxt   = o_sa_r;
    o_ds_nxt   = o_ds_r;
    o_da_nxt   = o_da_r;
    o_ol_nxt   = o_ol_r;
    o_tl_nxt   = o_tl_r;
    o_err_nxt  = o_err_r;
    o_last_nxt = o_last_r;

    ram_we    = 1'b0;
    ram_waddr = iss_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = iss_addr;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        iss_nxt = '0;
        rcv_nxt = '0;
        if (in_accept) begin
          if (req_err) begin
            o_res_nxt  = in_resource;
            o_base_nxt = '0;
            o_cnt_nxt  = '0;
            o_ss_nxt   = '0;
            o_sa_nxt   = '0;
            o_ds_nxt   = '0;
            o_da_nxt   = '0;
            o_ol_nxt   = '0;
            o_tl_nxt   = '0;
            o_err_nxt  = 1'b1;
            o_last_nxt = 1'b1;
            state_nxt  = ST_EMIT;
          end else begin
            state_nxt = ST_GATHER;
          end
        end
      end

      ST_GATHER: begin
        // Issue one read a cycle; data returns in the following cycle into the accumulator.
        if (iss_more) begin
          ram_re   = 1'b1;
          iss_nxt  = iss_r + CNT_W'(1);
          rvld_nxt = 1'b1;
        end
        if (rvld_r) begin
          rcv_nxt = rcv_r + CNT_W'(1);
          if (rcv_last) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        iss_nxt = '0;
        rcv_nxt = '0;
        if (!hazard) begin
          state_nxt = ST_ORW;
        end else if (mixed_eff) begin
          state_nxt = ST_MIXRD;
        end else begin
          o_res_nxt  = res_r;
          o_base_nxt = base_r;
          o_cnt_nxt  = cnt_r;
          o_ss_nxt   = acc.stages;
          o_sa_nxt   = acc.rd | acc.wr;
          o_ds_nxt   = ns_r;
          o_da_nxt   = nr_r | nw_r;
          o_ol_nxt   = img_r ? ol_eff : LAYOUT_UNDEFINED;
          o_tl_nxt   = img_r ? nl_r : LAYOUT_UNDEFINED;
          o_err_nxt  = 1'b0;
          o_last_nxt = 1'b1;
          state_nxt  = ST_OVW;
        end
      end

      ST_ORW: begin
        // Read-modify-write pass that ORs the new masks into every mip.
        if (iss_more) begin
          ram_re   = 1'b1;
          iss_nxt  = iss_r + CNT_W'(1);
          rvld_nxt = 1'b1;
        end
        if (rvld_r) begin
          ram_we           = 1'b1;
          ram_waddr        = rcv_addr;
          ram_wdata.stages = ram_rdata.stages | ns_r;
          ram_wdata.rd     = ram_rdata.rd | nr_r;
          ram_wdata.wr     = ram_rdata.wr | nw_r;
          ram_wdata.layout = ram_rdata.layout;
          rcv_nxt          = rcv_r + CNT_W'(1);
          if (rcv_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_OVW: begin
        // A buffer keeps whatever layout its entry holds.
        ram_we           = 1'b1;
        ram_wdata.stages = ns_r;
        ram_wdata.rd     = nr_r;
        ram_wdata.wr     = nw_r;
        ram_wdata.layout = img_r ? nl_r : acc.first_layout;
        iss_nxt          = iss_r + CNT_W'(1);
        if (iss_last) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_accept) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_MIXRD: begin
        ram_re    = 1'b1;
        state_nxt = ST_MIXWT;
      end

      ST_MIXWT: begin
        // The old entry goes to the output register before it is overwritten.
        o_res_nxt  = res_r;
        o_base_nxt = base_r + iss_r[MIP_W-1:0];
        o_cnt_nxt  = CNT_W'(1);
        o_ss_nxt   = ram_rdata.stages;
        o_sa_nxt   = ram_rdata.rd | ram_rdata.wr;
        o_ds_nxt   = ns_r;
        o_da_nxt   = nr_r | nw_r;
        o_ol_nxt   = ram_rdata.layout;
        o_tl_nxt   = nl_r;
        o_err_nxt  = 1'b0;
        o_last_nxt = iss_last;

        ram_we           = 1'b1;
        ram_wdata.stages = ns_r;
        ram_wdata.rd     = nr_r;
        ram_wdata.wr     = nw_r;
        ram_wdata.layout = nl_r;
        state_nxt        = ST_MIXOUT;
      end

      ST_MIXOUT: begin
        if (out_accept) begin
          if (iss_last) begin
            state_nxt = ST_IDLE;
          end else begin
            iss_nxt   = iss_r + CNT_W'(1);
            state_nxt = ST_MIXRD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      iss_r      <= '0;
      rcv_r      <= '0;
      rvld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      iss_r      <= iss_nxt;
      rcv_r      <= rcv_nxt;
      rvld_r     <= rvld_nxt;
    end
  end

  // Request and output payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r   <= in_resource;
      img_r   <= in_is_image;
      base_r  <= in_is_image ? in_base_mip : '0;
      cnt_r   <= in_is_image ? in_mip_count : CNT_W'(1);
      ns_r    <= in_new_stages;
      nr_r    <= in_new_read;
      nw_r    <= in_new_write;
      nl_r    <= in_new_layout;
      disc_r  <= in_is_image && in_discard;
      baddr_r <= ADDR_W'(in_resource) * ADDR_W'(MAX_MIPS) +
                 ADDR_W'(in_is_image ? in_base_mip : '0);
    end
    o_res_r  <= o_res_nxt;
    o_base_r <= o_base_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_ss_r   <= o_ss_nxt;
    o_sa_r   <= o_sa_nxt;
    o_ds_r   <= o_ds_nxt;
    o_da_r   <= o_da_nxt;
    o_ol_r   <= o_ol_nxt;
    o_tl_r   <= o_tl_nxt;
    o_err_r  <= o_err_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_barrier_resource  = o_res_r;
  assign out_barrier_base_mip  = o_base_r;
  assign out_barrier_mip_count = o_cnt_r;
  assign out_wait_stages       = o_ss_r;
  assign out_wait_access       = o_sa_r;
  assign out_next_stages       = o_ds_r;
  assign out_next_access       = o_da_r;
  assign out_prior_layout      = o_ol_r;
  assign out_target_layout     = o_tl_r;
  assign out_range_error       = o_err_r;
  assign out_last              = o_last_r;

  // No new request is taken while a barrier waits to be delivered.
  a_no_accept_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while a barrier is pending");

  // A rejected request produces a single, final transaction.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> out_last)
    else $error("range error result not marked last");

  // A real barrier always covers at least one mip.
  a_barrier_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error) |-> (out_barrier_mip_count != '0))
    else $error("barrier with an empty mip range");

  // The clearing pass after reset keeps the input closed.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

endmodule

`default_nettype wire

/* test/rhbt_barrier_checker.sv */
// Scoreboard for the resource hazard barrier tracker: watches both channels,
// keeps its own copy of the per-mip tables and compares every barrier.
// Depends on rhbt_pkg for widths and the undefined layout code.

module rhbt_barrier_checker
  import rhbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [RES_W-1:0]    in_resource,
  input  logic                in_is_image,
  input  logic [MIP_W-1:0]    in_base_mip,
  input  logic [CNT_W-1:0]    in_mip_count,
  input  logic [MASK_W-1:0]   in_new_stages,
  input  logic [MASK_W-1:0]   in_new_read,
  input  logic [MASK_W-1:0]   in_new_write,
  input  logic [LAYOUT_W-1:0] in_new_layout,
  input  logic                in_discard,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [RES_W-1:0]    out_barrier_resource,
  input  logic [MIP_W-1:0]    out_barrier_base_mip,
  input  logic [CNT_W-1:0]    out_barrier_mip_count,
  input  logic [MASK_W-1:0]   out_wait_stages,
  input  logic [MASK_W-1:0]   out_wait_access,
  input  logic [MASK_W-1:0]   out_next_stages,
  input  logic [MASK_W-1:0]   out_next_access,
  input  logic [LAYOUT_W-1:0] out_prior_layout,
  input  logic [LAYOUT_W-1:0] out_target_layout,
  input  logic                out_range_error,
  input  logic                out_last,
  output int                  mismatch_count,
  output int                  pending_count,
  output int                  requests_seen,
  output int                  barriers_seen,
  output int                  split_barriers,
  output int                  error_results,
  output int                  quiet_requests
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RES_W-1:0]    resource;
    logic [MIP_W-1:0]    base_mip;
    logic [CNT_W-1:0]    mip_count;
    logic [MASK_W-1:0]   wait_stages;
    logic [MASK_W-1:0]   wait_access;
    logic [MASK_W-1:0]   next_stages;
    logic [MASK_W-1:0]   next_access;
    logic [LAYOUT_W-1:0] prior_layout;
    logic [LAYOUT_W-1:0] target_layout;
    logic                range_error;
    logic                last;
  } barrier_t;

  logic [MASK_W-1:0]   stage_tab  [TABLE_DEPTH];
  logic [MASK_W-1:0]   read_tab   [TABLE_DEPTH];
  logic [MASK_W-1:0]   write_tab  [TABLE_DEPTH];
  logic [LAYOUT_W-1:0] layout_tab [TABLE_DEPTH];

  barrier_t expected_barriers[$];

  int mismatches = 0;
  int n_requests = 0;
  int n_barriers = 0;
  int n_split    = 0;
  int n_errors   = 0;
  int n_quiet    = 0;

  function automatic barrier_t make_barrier(
    input logic [RES_W-1:0] res, input logic [MIP_W-1:0] base,
    input logic [CNT_W-1:0] cnt, input logic [MASK_W-1:0] ss, input logic [MASK_W-1:0] sa,
    input logic [MASK_W-1:0] ds, input logic [MASK_W-1:0] da,
    input logic [LAYOUT_W-1:0] ol, input logic [LAYOUT_W-1:0] tl,
    input logic err, input logic fin);
    barrier_t b;
    b.resource      = res;
    b.base_mip      = base;
    b.mip_count     = cnt;
    b.wait_stages   = ss;
    b.wait_access   = sa;
    b.next_stages   = ds;
    b.next_access   = da;
    b.prior_layout  = ol;
    b.target_layout = tl;
    b.range_error   = err;
    b.last          = fin;
    return b;
  endfunction

  function automatic string describe(input barrier_t b);
    return $sformatf("res %0d mips %0d+%0d src %h/%h dst %h/%h layout %0d->%0d err %b last %b",
                     b.resource, b.base_mip, b.mip_count, b.wait_stages, b.wait_access,
                     b.next_stages, b.next_access, b.prior_layout, b.target_layout,
                     b.range_error, b.last);
  endfunction

  // Works out the barriers one request causes and updates the shadow tables.
  // A buffer is treated as a one-mip range at mip 0 that never has a layout.
  task automatic predict_barriers(
    input logic [RES_W-1:0] res, input logic img, input logic [MIP_W-1:0] base,
    input logic [CNT_W-1:0] cnt, input logic [MASK_W-1:0] ns, input logic [MASK_W-1:0] nr,
    input logic [MASK_W-1:0] nw, input logic [LAYOUT_W-1:0] nl, input logic disc);
    int lo_idx;
    int hi_idx;
    int m;
    logic [MASK_W-1:0] old_st;
    logic [MASK_W-1:0] old_rd;
    logic [MASK_W-1:0] old_wr;
    logic [LAYOUT_W-1:0] from_layout;
    logic [LAYOUT_W-1:0] to_layout;
    logic mixed;
    n_requests++;
    if (int'(res) >= NUM_RESOURCES ||
        (img && (cnt == '0 || int'(base) + int'(cnt) > MAX_MIPS))) begin
      expected_barriers.push_back(make_barrier(res, '0, '0, '0, '0, '0, '0,
                                               LAYOUT_UNDEFINED,
                                               LAYOUT_UNDEFINED, 1'b1, 1'b1));
      n_errors++;
      return;
    end
    lo_idx = int'(res) * MAX_MIPS + (img ? int'(base) : 0);
    hi_idx = lo_idx + (img ? int'(cnt) : 1);
    old_st = '0;
    old_rd = '0;
    old_wr = '0;
    mixed = 1'b0;
    from_layout = img ? layout_tab[lo_idx] : LAYOUT_UNDEFINED;
    to_layout = img ? nl : LAYOUT_UNDEFINED;
    for (m = lo_idx; m < hi_idx; m++) begin
      if (img && layout_tab[m] != from_layout) mixed = 1'b1;
      old_st |= stage_tab[m];
      old_rd |= read_tab[m];
      old_wr |= write_tab[m];
    end
    // Discarding the old contents makes the range one undefined layout.
    if (img && disc) begin
      from_layout = LAYOUT_UNDEFINED;
      mixed = 1'b0;
    end
    if (!mixed && old_wr == '0 && (old_rd == '0 || nw == '0) && from_layout == to_layout) begin
      for (m = lo_idx; m < hi_idx; m++) begin
        stage_tab[m] |= ns;
        read_tab[m]  |= nr;
        write_tab[m] |= nw;
      end
      n_quiet++;
      return;
    end
    if (!mixed) begin
      expected_barriers.push_back(make_barrier(res, img ? base : '0, img ? cnt : CNT_W'(1),
                                               old_st, old_rd | old_wr, ns, nr | nw,
                                               from_layout, to_layout, 1'b0, 1'b1));
    end else begin
      for (m = lo_idx; m < hi_idx; m++) begin
        expected_barriers.push_back(make_barrier(res, MIP_W'(int'(base) + m - lo_idx),
                                                 CNT_W'(1), stage_tab[m],
                                                 read_tab[m] | write_tab[m], ns, nr | nw,
                                                 layout_tab[m], nl, 1'b0, m + 1 == hi_idx));
        n_split++;
      end
    end
    for (m = lo_idx; m < hi_idx; m++) begin
      stage_tab[m] = ns;
      read_tab[m]  = nr;
      write_tab[m] = nw;
      if (img) layout_tab[m] = nl;
    end
  endtask

  always @(posedge clk) begin
    barrier_t seen;
    barrier_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        stage_tab[i]  = '0;
        read_tab[i]   = '0;
        write_tab[i]  = '0;
        layout_tab[i] = LAYOUT_UNDEFINED;
      end
      expected_barriers.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_barriers(in_resource, in_is_image, in_base_mip, in_mip_count, in_new_stages,
                         in_new_read, in_new_write, in_new_layout, in_discard);
      end
      if (out_valid && !out_stall) begin
        n_barriers++;
        seen = make_barrier(out_barrier_resource, out_barrier_base_mip, out_barrier_mip_count,
                            out_wait_stages, out_wait_access, out_next_stages, out_next_access,
                            out_prior_layout, out_target_layout, out_range_error, out_last);
        if (expected_barriers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("[%0t] unexpected barrier: %s", $realtime,
                                         describe(seen));
        end else begin
          want = expected_barriers.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] barrier mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= expected_barriers.size();
    requests_seen  <= n_requests;
    barriers_seen  <= n_barriers;
    split_barriers <= n_split;
    error_results  <= n_errors;
    quiet_requests <= n_quiet;
  end

endmodule

/* test/tb_top.sv */
// Top of the barrier tracker testbench: clock, reset, request stimulus and
// random output back-pressure. Depends on rhbt_pkg, the tracker RTL and
// rhbt_barrier_checker, which does all prediction and comparison.

module tb_top;

  import rhbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Number of random requests after the directed ones.
  localparam int RANDOM_REQUESTS = 400;
  // One long output hold, long enough to back the block up into its input.
  localparam int HOLD_CYCLES     = 600;
  // Quiet time after the last barrier, long enough for a 16-mip fold without a result.
  localparam int DRAIN_CYCLES    = 200;
  // Generous cap: clearing pass plus every request at its slowest, several times over.
  localparam int CYCLE_LIMIT     = 2000000;

  typedef struct {
    logic [RES_W-1:0]    resource;
    logic                is_image;
    logic [MIP_W-1:0]    base_mip;
    logic [CNT_W-1:0]    mips;
    logic [MASK_W-1:0]   stages;
    logic [MASK_W-1:0]   rd;
    logic [MASK_W-1:0]   wr;
    logic [LAYOUT_W-1:0] layout;
    logic                discard;
  } request_t;

  localparam logic [MASK_W-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n;

  logic                in_valid;
  logic                in_stall;
  logic [RES_W-1:0]    in_resource;
  logic                in_is_image;
  logic [MIP_W-1:0]    in_base_mip;
  logic [CNT_W-1:0]    in_mip_count;
  logic [MASK_W-1:0]   in_new_stages;
  logic [MASK_W-1:0]   in_new_read;
  logic [MASK_W-1:0]   in_new_write;
  logic [LAYOUT_W-1:0] in_new_layout;
  logic                in_discard;

  logic                out_valid;
  logic                out_stall;
  logic [RES_W-1:0]    out_barrier_resource;
  logic [MIP_W-1:0]    out_barrier_base_mip;
  logic [CNT_W-1:0]    out_barrier_mip_count;
  logic [MASK_W-1:0]   out_wait_stages;
  logic [MASK_W-1:0]   out_wait_access;
  logic [MASK_W-1:0]   out_next_stages;
  logic [MASK_W-1:0]   out_next_access;
  logic [LAYOUT_W-1:0] out_prior_layout;
  logic [LAYOUT_W-1:0] out_target_layout;
  logic                out_range_error;
  logic                out_last;

  int mismatch_count;
  int pending_count;
  int requests_seen;
  int barriers_seen;
  int split_barriers;
  int error_results;
  int quiet_requests;

  int  cycle_count = 0;
  // Raised by the request driver once; the output side answers with a long hold.
  logic hold_req = 1'b0;

  always #6 clk = ~clk;

  resource_hazard_barrier_tracker uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_resource           (in_resource),
    .in_is_image           (in_is_image),
    .in_base_mip           (in_base_mip),
    .in_mip_count          (in_mip_count),
    .in_new_stages         (in_new_stages),
    .in_new_read           (in_new_read),
    .in_new_write          (in_new_write),
    .in_new_layout         (in_new_layout),
    .in_discard            (in_discard),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_barrier_resource  (out_barrier_resource),
    .out_barrier_base_mip  (out_barrier_base_mip),
    .out_barrier_mip_count (out_barrier_mip_count),
    .out_wait_stages       (out_wait_stages),
    .out_wait_access       (out_wait_access),
    .out_next_stages       (out_next_stages),
    .out_next_access       (out_next_access),
    .out_prior_layout      (out_prior_layout),
    .out_target_layout     (out_target_layout),
    .out_range_error       (out_range_error),
    .out_last              (out_last)
  );

  rhbt_barrier_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_resource           (in_resource),
    .in_is_image           (in_is_image),
    .in_base_mip           (in_base_mip),
    .in_mip_count          (in_mip_count),
    .in_new_stages         (in_new_stages),
    .in_new_read           (in_new_read),
    .in_new_write          (in_new_write),
    .in_new_layout         (in_new_layout),
    .in_discard            (in_discard),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_barrier_resource  (out_barrier_resource),
    .out_barrier_base_mip  (out_barrier_base_mip),
    .out_barrier_mip_count (out_barrier_mip_count),
    .out_wait_stages       (out_wait_stages),
    .out_wait_access       (out_wait_access),
    .out_next_stages       (out_next_stages),
    .out_next_access       (out_next_access),
    .out_prior_layout      (out_prior_layout),
    .out_target_layout     (out_target_layout),
    .out_range_error       (out_range_error),
    .out_last              (out_last),
    .mismatch_count        (mismatch_count),
    .pending_count         (pending_count),
    .requests_seen         (requests_seen),
    .barriers_seen         (barriers_seen),
    .split_barriers        (split_barriers),
    .error_results         (error_results),
    .quiet_requests        (quiet_requests)
  );

  // Watchdog. A hung handshake or a lost barrier ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d barriers still expected",
               cycle_count, pending_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // An image request. Every field is taken as given, so bad ranges can be built too.
  function automatic request_t image_req(
    input int res, input int base, input int cnt, input logic [MASK_W-1:0] st,
    input logic [MASK_W-1:0] rd, input logic [MASK_W-1:0] wr, input int lay, input bit disc);
    request_t r;
    r.resource = RES_W'(res);
    r.is_image = 1'b1;
    r.base_mip = MIP_W'(base);
    r.mips     = CNT_W'(cnt);
    r.stages   = st;
    r.rd       = rd;
    r.wr       = wr;
    r.layout   = LAYOUT_W'(lay);
    r.discard  = disc;
    return r;
  endfunction

  // A buffer request. The mip range, layout and discard are ignored by the
  // block, so they carry junk to prove that.
  function automatic request_t buffer_req(
    input int res, input logic [MASK_W-1:0] st, input logic [MASK_W-1:0] rd,
    input logic [MASK_W-1:0] wr);
    request_t r;
    r = image_req(res, $urandom_range(0, 15), $urandom_range(0, 31), st, rd, wr,
                  $urandom_range(0, 255), $urandom_range(0, 1));
    r.is_image = 1'b0;
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] wide_random();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MASK_W-1:0];
  endfunction

  // Sparse masks dominate so that reads pile up quietly before a write hits them;
  // full-width random and all-ones masks exercise every bit.
  function automatic logic [MASK_W-1:0] pick_mask(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return '0;
    if (r < zero_pct + (100 - zero_pct) / 2) return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
    if (r < 90) return wide_random();
    return ALL_ONES;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int kind;
    int res;
    int base;
    int cnt;
    int lay;
    kind = $urandom_range(0, 99);
    // A handful of hot resources keeps the tables busy; the rest spreads out.
    res = ($urandom_range(0, 3) < 3) ? $urandom_range(0, 5) : $urandom_range(0, 63);
    lay = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    if (kind < 15) begin
      return buffer_req(res, pick_mask(10), pick_mask(30), pick_mask(60));
    end
    if (kind < 24) begin
      // Broken range: zero levels, or a range that runs past the last mip.
      base = $urandom_range(0, 15);
      cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(17 - base, 31);
    end else if (kind < 70) begin
      cnt = $urandom_range(1, 3);
      base = $urandom_range(0, 16 - cnt);
    end else if (kind < 82) begin
      cnt = 16;
      base = 0;
    end else begin
      cnt = $urandom_range(1, 16);
      base = $urandom_range(0, 16 - cnt);
    end
    r = image_req(res, base, cnt, pick_mask(10), pick_mask(30), pick_mask(60), lay,
                  $urandom_range(0, 99) < 15);
    return r;
  endfunction

  // Gap after a transaction: mostly back to back, sometimes a few cycles,
  // rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one request and holds it steady until the block takes it. With no
  // gap, valid simply stays high and the next request follows at once.
  task automatic issue_request(input request_t r, input int gap);
    in_valid      <= 1'b1;
    in_resource   <= r.resource;
    in_is_image   <= r.is_image;
    in_base_mip   <= r.base_mip;
    in_mip_count  <= r.mips;
    in_new_stages <= r.stages;
    in_new_read   <= r.rd;
    in_new_write  <= r.wr;
    in_new_layout <= r.layout;
    in_discard    <= r.discard;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Output side: random stalls, short ones mostly, with long free stretches and
  // the occasional long stall. When the driver asks for it, one very long hold
  // lets the block fill up while requests keep coming.
  initial begin
    int r;
    int len;
    logic stall_val;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        stall_val = 1'b1;
        len = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          stall_val = 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 55) begin
          stall_val = 1'b0;
          len = $urandom_range(10, 60);
        end else if (r < 92) begin
          stall_val = 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          stall_val = 1'b1;
          len = $urandom_range(10, 40);
        end
      end
      out_stall <= stall_val;
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    in_valid      <= 1'b0;
    in_resource   <= '0;
    in_is_image   <= 1'b0;
    in_base_mip   <= '0;
    in_mip_count  <= '0;
    in_new_stages <= '0;
    in_new_read   <= '0;
    in_new_write  <= '0;
    in_new_layout <= LAYOUT_UNDEFINED;
    in_discard    <= 1'b0;
    rst_n         <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Buffer 0 walks through a plain read, then a write after
    // read, a write after write and a read after write.
    issue_request(buffer_req(0, 48'h1, 48'h1, '0), pick_gap());
    issue_request(buffer_req(0, 48'h2, '0, 48'h2), pick_gap());
    issue_request(buffer_req(0, 48'h4, '0, 48'h4), pick_gap());
    issue_request(buffer_req(0, 48'h8, 48'h8, '0), pick_gap());
    // Highest resource with full masks: the first write to a clean entry is
    // quiet, then a read of that write needs a barrier.
    issue_request(buffer_req(63, ALL_ONES, '0, ALL_ONES), pick_gap());
    issue_request(buffer_req(63, '0, ALL_ONES, '0), pick_gap());
    // Image 1: a layout change over all sixteen mips, a quiet read of part of
    // the range, a write with a new layout on that part, then a read of the
    // whole image whose mips now disagree on layout, so one barrier per mip.
    issue_request(image_req(1, 0, 16, 48'h1, 48'h1, '0, 5, 1'b0), pick_gap());
    issue_request(image_req(1, 4, 4, 48'h2, 48'h2, '0, 5, 1'b0), pick_gap());
    issue_request(image_req(1, 4, 4, 48'h4, '0, 48'h4, 9, 1'b0), pick_gap());
    issue_request(image_req(1, 0, 16, 48'h8, 48'h8, '0, 9, 1'b0), pick_gap());
    // Last mip alone with the widest layout code and full masks.
    issue_request(image_req(1, 15, 1, ALL_ONES, ALL_ONES, ALL_ONES, 255, 1'b0), pick_gap());
    // Discard over mixed layouts: the range counts as undefined, one barrier.
    issue_request(image_req(1, 0, 16, 48'h1, '0, '0, 0, 1'b1), pick_gap());
    // Discard with nothing pending and the layout already undefined: quiet.
    issue_request(image_req(1, 0, 16, 48'h2, 48'h2, '0, 0, 1'b1), pick_gap());
    issue_request(image_req(2, 3, 2, '0, '0, '0, 0, 1'b0), pick_gap());
    // Bad ranges: past the last mip, zero levels, seventeen levels, and the
    // widest count the field allows.
    issue_request(image_req(2, 15, 2, 48'h1, 48'h1, 48'h1, 1, 1'b0), pick_gap());
    issue_request(image_req(2, 0, 0, 48'h1, 48'h1, 48'h1, 1, 1'b0), pick_gap());
    issue_request(image_req(2, 0, 17, 48'h1, 48'h1, 48'h1, 1, 1'b1), pick_gap());
    issue_request(image_req(63, 15, 31, ALL_ONES, ALL_ONES, ALL_ONES, 255, 1'b1), pick_gap());
    issue_request(image_req(62, 0, 1, '0, '0, '0, 255, 1'b0), pick_gap());
    // Resource 5 used first as a buffer and then as an image: the buffer write
    // sits in mip 0, and the two-mip read afterwards sees mixed layouts.
    issue_request(buffer_req(5, 48'h5555_5555_5555, '0, ALL_ONES), pick_gap());
    issue_request(image_req(5, 0, 1, 48'h10, 48'h10, '0, 3, 1'b0), pick_gap());
    issue_request(image_req(5, 0, 2, 48'h20, 48'h20, '0, 3, 1'b0), pick_gap());

    // Random part. A third of the way in, the output side holds off for a
    // long stretch while requests keep arriving.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 3) hold_req = 1'b1;
      issue_request(random_request(), pick_gap());
    end
    in_valid <= 1'b0;

    // Drain: wait for the last expected barrier, then give the block time to
    // finish any request that produces no barrier.
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d quiet merges, %0d range errors, %0d barriers",
             requests_seen, quiet_requests, error_results, barriers_seen);
    $display("Per-mip barriers from mixed layouts: %0d", split_barriers);
    if (pending_count != 0) $display("%0d expected barriers never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
